// ===== rtl/hxt_pkg.sv =====
// package: types, constants and command bundles of the hextile tile decoder
`timescale 1ns / 1ps
package hxt_pkg;
  localparam int TILE_SIZE = 16;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [2:0] BPP_RESET = 3'd4;

  localparam int FLAG_RAW = 0;
  localparam int FLAG_BG = 1;
  localparam int FLAG_FG = 2;
  localparam int FLAG_ANY = 3;
  localparam int FLAG_COLOURED = 4;

  localparam logic [1:0] KIND_FILL = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_INV = 2'd2;

  localparam logic OP_BEGIN = 1'b0;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SUBENC, PH_RAW, PH_BG, PH_FG, PH_NSUB, PH_SCOLOR, PH_SXY, PH_SWH
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [31:0] color;
  } cmd_t;

  typedef struct packed {
    logic [1:0] n;
    cmd_t       c0;
    cmd_t       c1;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;
endpackage

// ===== rtl/hxt_if.sv =====
// interfaces: input byte channel and command result channel
`timescale 1ns / 1ps
interface hxt_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  data_byte;
  logic [15:0] rect_x;
  logic [15:0] rect_y;
  logic [15:0] rect_w;
  logic [15:0] rect_h;
  modport source (output valid, operation, data_byte, rect_x, rect_y, rect_w, rect_h,
                  input ready);
  modport sink (input valid, operation, data_byte, rect_x, rect_y, rect_w, rect_h,
                output ready);
endinterface

interface hxt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd_kind;
  logic [15:0] out_x;
  logic [15:0] out_y;
  logic [15:0] out_w;
  logic [15:0] out_h;
  logic [31:0] color;
  logic        last;
  modport source (output valid, cmd_kind, out_x, out_y, out_w, out_h, color, last,
                  input ready);
  modport sink (input valid, cmd_kind, out_x, out_y, out_w, out_h, color, last,
                output ready);
endinterface

// ===== rtl/hxt_front.sv =====
// front: hextile stream parser, one byte per cycle while take is high, builds command jobs
`timescale 1ns / 1ps
module hxt_front #(
  parameter int COORD_WIDTH = hxt_pkg::COORD_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic            operation,
  input  logic [7:0]      data_byte,
  input  logic [15:0]     rect_x,
  input  logic [15:0]     rect_y,
  input  logic [15:0]     rect_w,
  input  logic [15:0]     rect_h,
  input  logic [2:0]      bpp,
  output logic            push,
  output hxt_pkg::job_t   job
);
  localparam logic [15:0] CMASK = 16'((32'h1 << COORD_WIDTH) - 1);

  hxt_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] ox_r, oy_r, rw_r, rh_r, ox_nxt, oy_nxt, rw_nxt, rh_nxt;
  logic [15:0] tx_r, ty_r, tx_nxt, ty_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [31:0] bg_r, fg_r, acc_r, bg_nxt, fg_nxt, acc_nxt;
  logic [7:0]  left_r, left_nxt, pos_r, pos_nxt;
  logic [1:0]  bidx_r, bidx_nxt;
  logic [3:0]  col_r, row_r, col_nxt, row_nxt;

  logic [15:0] remw, remh;
  logic [4:0]  tw, th;
  logic [2:0]  pb;
  logic [31:0] acc_in;
  logic        pdone;
  logic        emit_a, do_abg, do_afg, do_nt, inv;
  hxt_pkg::cmd_t ca, ci;
  logic [16:0] sx, sy;
  logic [7:0]  b;

  always_comb begin
    b = data_byte;
    remw = rw_r - tx_r;
    remh = rh_r - ty_r;
    tw = (remw < 16'(hxt_pkg::TILE_SIZE)) ? remw[4:0] : 5'(hxt_pkg::TILE_SIZE);
    th = (remh < 16'(hxt_pkg::TILE_SIZE)) ? remh[4:0] : 5'(hxt_pkg::TILE_SIZE);
    pb = (bpp == 3'd0) ? 3'd1 : ((bpp > 3'd4) ? 3'd4 : bpp);
    acc_in = acc_r | ({24'd0, b} << {bidx_r, 3'b000});
    pdone = ({1'b0, bidx_r} + 3'd1) >= pb;

    phase_nxt = phase_r;
    ox_nxt = ox_r; oy_nxt = oy_r; rw_nxt = rw_r; rh_nxt = rh_r;
    tx_nxt = tx_r; ty_nxt = ty_r; flags_nxt = flags_r;
    bg_nxt = bg_r; fg_nxt = fg_r; acc_nxt = acc_r;
    left_nxt = left_r; pos_nxt = pos_r; bidx_nxt = bidx_r;
    col_nxt = col_r; row_nxt = row_r;
    emit_a = 1'b0; do_abg = 1'b0; do_afg = 1'b0; do_nt = 1'b0; inv = 1'b0;
    ca = '0; ci = '0;
    sx = {1'b0, tx_r} + 17'(hxt_pkg::TILE_SIZE);
    sy = {1'b0, ty_r} + 17'(hxt_pkg::TILE_SIZE);

    if (take) begin
      if (operation == hxt_pkg::OP_BEGIN) begin
        ox_nxt = rect_x; oy_nxt = rect_y; rw_nxt = rect_w; rh_nxt = rect_h;
        tx_nxt = '0; ty_nxt = '0; flags_nxt = '0; bg_nxt = '0; fg_nxt = '0;
        left_nxt = '0; pos_nxt = '0; acc_nxt = '0; bidx_nxt = '0;
        col_nxt = '0; row_nxt = '0;
        phase_nxt = (rect_w == 16'd0 || rect_h == 16'd0) ? hxt_pkg::PH_IDLE
                                                         : hxt_pkg::PH_SUBENC;
      end else begin
        case (phase_r)
          hxt_pkg::PH_SUBENC: begin
            flags_nxt = b; acc_nxt = '0; bidx_nxt = '0;
            if (b[hxt_pkg::FLAG_RAW]) begin
              col_nxt = '0; row_nxt = '0; phase_nxt = hxt_pkg::PH_RAW;
            end else if (b[hxt_pkg::FLAG_BG]) begin
              phase_nxt = hxt_pkg::PH_BG;
            end else begin
              do_abg = 1'b1;
            end
          end
          hxt_pkg::PH_RAW: begin
            acc_nxt = acc_in;
            bidx_nxt = pdone ? 2'd0 : bidx_r + 2'd1;
            if (pdone) begin
              emit_a = 1'b1;
              ca.kind = hxt_pkg::KIND_PIXEL;
              ca.x = (ox_r + tx_r + 16'(col_r)) & CMASK;
              ca.y = (oy_r + ty_r + 16'(row_r)) & CMASK;
              ca.w = 16'd1; ca.h = 16'd1; ca.color = acc_in;
              acc_nxt = '0;
              if ({1'b0, col_r} == tw - 5'd1) begin
                col_nxt = '0; row_nxt = row_r + 4'd1;
                if ({1'b0, row_r} == th - 5'd1) do_nt = 1'b1;
              end else begin
                col_nxt = col_r + 4'd1;
              end
            end
          end
          hxt_pkg::PH_BG: begin
            acc_nxt = acc_in;
            bidx_nxt = pdone ? 2'd0 : bidx_r + 2'd1;
            if (pdone) begin
              bg_nxt = acc_in; do_abg = 1'b1;
            end
          end
          hxt_pkg::PH_FG: begin
            acc_nxt = acc_in;
            bidx_nxt = pdone ? 2'd0 : bidx_r + 2'd1;
            if (pdone) begin
              fg_nxt = acc_in; do_afg = 1'b1;
            end
          end
          hxt_pkg::PH_NSUB: begin
            left_nxt = b;
            if (b == 8'd0) begin
              do_nt = 1'b1;
            end else begin
              acc_nxt = '0; bidx_nxt = '0;
              phase_nxt = flags_r[hxt_pkg::FLAG_COLOURED] ? hxt_pkg::PH_SCOLOR
                                                          : hxt_pkg::PH_SXY;
            end
          end
          hxt_pkg::PH_SCOLOR: begin
            acc_nxt = acc_in;
            bidx_nxt = pdone ? 2'd0 : bidx_r + 2'd1;
            if (pdone) phase_nxt = hxt_pkg::PH_SXY;
          end
          hxt_pkg::PH_SXY: begin
            pos_nxt = b; phase_nxt = hxt_pkg::PH_SWH;
          end
          hxt_pkg::PH_SWH: begin
            emit_a = 1'b1;
            ca.kind = hxt_pkg::KIND_FILL;
            ca.x = (ox_r + tx_r + 16'(pos_r[7:4])) & CMASK;
            ca.y = (oy_r + ty_r + 16'(pos_r[3:0])) & CMASK;
            ca.w = 16'(b[7:4]) + 16'd1;
            ca.h = 16'(b[3:0]) + 16'd1;
            ca.color = flags_r[hxt_pkg::FLAG_COLOURED] ? acc_r : fg_r;
            left_nxt = left_r - 8'd1;
            if (left_r == 8'd1) begin
              do_nt = 1'b1;
            end else begin
              acc_nxt = '0; bidx_nxt = '0;
              phase_nxt = flags_r[hxt_pkg::FLAG_COLOURED] ? hxt_pkg::PH_SCOLOR
                                                          : hxt_pkg::PH_SXY;
            end
          end
          default: ;
        endcase

        if (do_abg) begin
          emit_a = 1'b1;
          ca.kind = hxt_pkg::KIND_FILL;
          ca.x = (ox_r + tx_r) & CMASK;
          ca.y = (oy_r + ty_r) & CMASK;
          ca.w = 16'(tw); ca.h = 16'(th); ca.color = bg_nxt;
          if (flags_nxt[hxt_pkg::FLAG_FG]) begin
            phase_nxt = hxt_pkg::PH_FG; acc_nxt = '0; bidx_nxt = '0;
          end else begin
            do_afg = 1'b1;
          end
        end
        if (do_afg) begin
          if (flags_nxt[hxt_pkg::FLAG_ANY]) phase_nxt = hxt_pkg::PH_NSUB;
          else do_nt = 1'b1;
        end
        if (do_nt) begin
          phase_nxt = hxt_pkg::PH_SUBENC;
          tx_nxt = sx[15:0];
          if (sx >= {1'b0, rw_r}) begin
            inv = 1'b1;
            ci.kind = hxt_pkg::KIND_INV;
            ci.x = ox_r & CMASK;
            ci.y = (oy_r + ty_r) & CMASK;
            ci.w = rw_r; ci.h = 16'(th); ci.color = '0;
            tx_nxt = '0;
            ty_nxt = sy[15:0];
            if (sy >= {1'b0, rh_r}) phase_nxt = hxt_pkg::PH_IDLE;
          end
        end
      end
    end

    push = emit_a || inv;
    job.n = {emit_a && inv, emit_a ^ inv};
    job.c0 = emit_a ? ca : ci;
    job.c1 = ci;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hxt_pkg::PH_IDLE;
      ox_r <= '0; oy_r <= '0; rw_r <= '0; rh_r <= '0;
      tx_r <= '0; ty_r <= '0; flags_r <= '0; bg_r <= '0; fg_r <= '0;
      acc_r <= '0; left_r <= '0; pos_r <= '0; bidx_r <= '0;
      col_r <= '0; row_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      ox_r <= ox_nxt; oy_r <= oy_nxt; rw_r <= rw_nxt; rh_r <= rh_nxt;
      tx_r <= tx_nxt; ty_r <= ty_nxt; flags_r <= flags_nxt;
      bg_r <= bg_nxt; fg_r <= fg_nxt; acc_r <= acc_nxt;
      left_r <= left_nxt; pos_r <= pos_nxt; bidx_r <= bidx_nxt;
      col_r <= col_nxt; row_r <= row_nxt;
    end
  end
endmodule

// ===== rtl/hxt_queue.sv =====
// queue: short job fifo between parser and command emitter
`timescale 1ns / 1ps
module hxt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hxt_pkg::job_t      push_data,
  input  logic               pop,
  output hxt_pkg::job_t      head,
  output hxt_pkg::q_status_t status
);
  localparam int AW = $clog2(hxt_pkg::QUEUE_DEPTH);

  hxt_pkg::job_t mem [hxt_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r, wp_nxt, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  always_comb begin
    status.empty = (cnt_r == '0);
    status.full = (cnt_r == (AW+1)'(hxt_pkg::QUEUE_DEPTH));
    head = mem[rp_r];
    wp_nxt = push ? wp_r + 1'b1 : wp_r;
    rp_nxt = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end
endmodule

// ===== rtl/hxt_back.sv =====
// back: takes jobs from the queue and sends their commands one word at a time
`timescale 1ns / 1ps
module hxt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  hxt_pkg::job_t      head,
  input  hxt_pkg::q_status_t status,
  output logic               pop,
  hxt_out_if.source          out_ch
);
  hxt_pkg::job_t job_r, job_nxt;
  logic busy_r, busy_nxt, idx_r, idx_nxt;
  logic fire, fin;
  hxt_pkg::cmd_t c;

  always_comb begin
    c = idx_r ? job_r.c1 : job_r.c0;
    out_ch.valid = busy_r;
    out_ch.cmd_kind = c.kind;
    out_ch.out_x = c.x;
    out_ch.out_y = c.y;
    out_ch.out_w = c.w;
    out_ch.out_h = c.h;
    out_ch.color = c.color;
    out_ch.last = idx_r || (job_r.n == 2'd1);
    fire = busy_r && out_ch.ready;
    fin = fire && out_ch.last;
    pop = !status.empty && (!busy_r || fin);
    job_nxt = job_r; busy_nxt = busy_r; idx_nxt = idx_r;
    if (pop) begin
      job_nxt = head; busy_nxt = 1'b1; idx_nxt = 1'b0;
    end else if (fin) begin
      busy_nxt = 1'b0;
    end else if (fire) begin
      idx_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; idx_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; idx_r <= idx_nxt;
    end
  end
endmodule

// ===== rtl/hextile_tile_decoder.sv =====
// top level: hextile rectangle decoder, parser front, job queue, command back
//  channel  dir  word
//  in_ch    in   operation, data_byte, rect_x/y/w/h
//  out_ch   out  cmd_kind, out_x/y/w/h, color, last
//  cfg_*    in   bytes_per_pixel write
// one input word per cycle while the job queue has room
// a word causing two commands holds the back end until both are sent
// output words are registered in the job queue and then in the back end's job register
// output stalls fill the four-job queue, then in_ch.ready drops
// synchronous active-low reset, bytes_per_pixel resets to 4
`timescale 1ns / 1ps
module hextile_tile_decoder #(
  parameter int COORD_WIDTH = hxt_pkg::COORD_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hxt_in_if.sink     in_ch,
  hxt_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data
);
  logic [2:0] bpp_r;
  logic take, push, pop;
  hxt_pkg::job_t job, head;
  hxt_pkg::q_status_t qs;

  always_ff @(posedge clk) begin
    if (!rst_n) bpp_r <= hxt_pkg::BPP_RESET;
    else if (cfg_we) bpp_r <= cfg_data;
  end

  assign in_ch.ready = !qs.full;
  assign take = in_ch.valid && in_ch.ready;

  hxt_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst_n, .take,
    .operation(in_ch.operation), .data_byte(in_ch.data_byte),
    .rect_x(in_ch.rect_x), .rect_y(in_ch.rect_y),
    .rect_w(in_ch.rect_w), .rect_h(in_ch.rect_h),
    .bpp(bpp_r), .push, .job
  );

  hxt_queue u_queue (
    .clk, .rst_n, .push, .push_data(job), .pop, .head, .status(qs)
  );

  hxt_back u_back (
    .clk, .rst_n, .head, .status(qs), .pop, .out_ch
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qs.full) else $error("job pushed into full queue");
  a_inv_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.cmd_kind == hxt_pkg::KIND_INV |-> out_ch.last)
    else $error("invalidate strip not last word");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qs.empty) else $error("pop from empty queue");
endmodule
